### src/mpq_pkg.sv
// Shared types and codes for the max priority queue.
// Used by mpq_cmp and max_priority_queue_unit; no dependencies.
package mpq_pkg;

   // Field widths fixed by the interface
   localparam int ID_W    = 32;
   localparam int PRIO_W  = 16;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 9;
   localparam int ENTRY_W = ID_W + PRIO_W;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   // One heap slot
   typedef struct packed {
      logic signed [ID_W-1:0] id;
      logic [PRIO_W-1:0]      prio;
   } entry_type;

   // Sift direction for the shared compare unit
   localparam logic DIR_UP   = 1'b0;
   localparam logic DIR_DOWN = 1'b1;

   // Decision of one sift level
   typedef struct packed {
      logic move;
      logic pick_right;
   } decision_type;

endpackage

### src/mpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word through the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mpq_cmp.sv
// Shared compare unit: decides one level of a sift up or a sift down.
// Depends on mpq_pkg.
module mpq_cmp (
   input  logic                          dir,
   input  logic [mpq_pkg::PRIO_W-1:0]    cur_prio,
   input  logic [mpq_pkg::PRIO_W-1:0]    cand_a_prio,
   input  logic [mpq_pkg::PRIO_W-1:0]    cand_b_prio,
   input  logic                          cand_b_ok,
   output mpq_pkg::decision_type         decision
);
   import mpq_pkg::*;

   logic [PRIO_W-1:0] cand_prio;
   logic [PRIO_W-1:0] lhs;
   logic [PRIO_W-1:0] rhs;
   logic              pick_right;

   // Choose the larger child; the right one wins a tie
   assign pick_right = (dir == DIR_DOWN) && cand_b_ok && !(cand_a_prio > cand_b_prio);
   assign cand_prio  = pick_right ? cand_b_prio : cand_a_prio;

   // Up moves when the entry beats its parent, down when the child beats the entry
   assign lhs = (dir == DIR_UP) ? cur_prio : cand_prio;
   assign rhs = (dir == DIR_UP) ? cand_prio : cur_prio;

   assign decision.move       = lhs > rhs;
   assign decision.pick_right = pick_right;

endmodule

### src/max_priority_queue_unit.sv
// Binary max-heap priority queue: sequencer, heap RAM and shared compare unit.
// Depends on mpq_pkg, mpq_ram and mpq_cmp.
//
// Usage:
//   Request channel (req_*): opcode 0 pushes (req_entry_id, req_priority_req),
//   opcode 1 pops the entry with the largest priority. Every item gives exactly
//   one response item (rsp_*) with the popped id and priority (zero unless a
//   pop succeeded), a status (done, push dropped when full, pop on empty) and
//   the entry count after the operation.
//   Timing: one item at a time. An entry moves at most log2(CAPACITY) levels
//   (8 for 256 entries), and the single RAM read port sets the pace: each
//   level reads the parent, or both children one after another, before the
//   compare unit decides and writes back.
//   The response sits in an output register; a new item is taken in the cycle
//   the previous response is taken. While rsp_stall is high the response
//   holds and req_stall stays high.
//   Reset empties the queue at once; the RAM contents need no clearing.
module max_priority_queue_unit #(
   parameter int CAPACITY = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic signed [mpq_pkg::ID_W-1:0]    req_entry_id,
   input  logic [mpq_pkg::PRIO_W-1:0]         req_priority_req,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mpq_pkg::ID_W-1:0]    rsp_popped_id,
   output logic [mpq_pkg::PRIO_W-1:0]         rsp_popped_priority,
   output logic [mpq_pkg::STAT_W-1:0]         rsp_status,
   output logic [mpq_pkg::COUNT_W-1:0]        rsp_entry_count
);
   import mpq_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_UP_CHK   = 4'd1;
   localparam logic [3:0] S_UP_CMP   = 4'd2;
   localparam logic [3:0] S_POP_RD0  = 4'd3;
   localparam logic [3:0] S_POP_RDL  = 4'd4;
   localparam logic [3:0] S_POP_LAST = 4'd5;
   localparam logic [3:0] S_DN_CHK   = 4'd6;
   localparam logic [3:0] S_DN_RDR   = 4'd7;
   localparam logic [3:0] S_DN_CMP   = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [IW-1:0]         pos_ff, pos_in;
   entry_type             cur_ff, cur_in;
   entry_type             left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [ID_W-1:0] res_id_ff, res_id_in;
   logic [PRIO_W-1:0]     res_prio_ff, res_prio_in;
   logic [STAT_W-1:0]     res_stat_ff, res_stat_in;
   logic [COUNT_W-1:0]    res_count_ff, res_count_in;

   logic                  req_take;
   logic                  rsp_take;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   entry_type             wr_data;
   logic [IW-1:0]         rd_addr;
   entry_type             rd_data;
   logic [ENTRY_W-1:0]    rd_bits;

   logic [IW-1:0]         parent_idx;
   logic [IW:0]           left_idx;
   logic [IW+1:0]         right_idx;
   logic                  left_ok;
   logic                  right_ok;
   logic                  dir;
   logic [PRIO_W-1:0]     cand_a_prio;
   decision_type          decision;

   // Heap storage
   mpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_data = rd_bits;

   // Tree index arithmetic
   assign parent_idx = (pos_ff - IW'(1)) >> 1;
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = (IW+2)'(left_idx) + (IW+2)'(1);
   assign left_ok    = left_idx < (IW+1)'(count_ff);
   assign right_ok   = right_idx < (IW+2)'(count_ff);

   // Shared compare unit
   assign dir         = (state_ff == S_DN_CMP) ? DIR_DOWN : DIR_UP;
   assign cand_a_prio = (state_ff == S_DN_CMP) ? left_ff.prio : rd_data.prio;

   mpq_cmp u_cmp (
      .dir         (dir),
      .cur_prio    (cur_ff.prio),
      .cand_a_prio (cand_a_prio),
      .cand_b_prio (rd_data.prio),
      .cand_b_ok   (right_ok),
      .decision    (decision)
   );

   // Handshakes
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      res_id_in    = res_id_ff;
      res_prio_in  = res_prio_ff;
      res_stat_in  = res_stat_ff;
      res_count_in = res_count_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;
      rd_addr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_id_in   = '0;
               res_prio_in = '0;
               if (req_opcode == OP_PUSH) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     // drop the push
                     rsp_valid_in = 1'b1;
                     res_stat_in  = ST_FULL;
                     res_count_in = COUNT_W'(count_ff);
                  end else begin
                     cur_in   = '{id: req_entry_id, prio: req_priority_req};
                     pos_in   = IW'(count_ff);
                     count_in = count_ff + CW'(1);
                     state_in = S_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     res_stat_in  = ST_EMPTY;
                     res_count_in = '0;
                  end else begin
                     state_in = S_POP_RD0;
                  end
               end
            end
         end

         S_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               res_stat_in  = ST_DONE;
               res_count_in = COUNT_W'(count_ff);
               state_in     = S_IDLE;
            end else begin
               rd_addr  = parent_idx;
               state_in = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            wr_en = 1'b1;
            if (decision.move) begin
               // move the parent down, climb one level
               wr_data  = rd_data;
               pos_in   = parent_idx;
               state_in = S_UP_CHK;
            end else begin
               rsp_valid_in = 1'b1;
               res_stat_in  = ST_DONE;
               res_count_in = COUNT_W'(count_ff);
               state_in     = S_IDLE;
            end
         end

         S_POP_RD0: begin
            rd_addr  = '0;
            state_in = S_POP_RDL;
         end

         S_POP_RDL: begin
            // capture the root, fetch the last entry
            res_id_in   = rd_data.id;
            res_prio_in = rd_data.prio;
            rd_addr     = IW'(count_ff - CW'(1));
            count_in    = count_ff - CW'(1);
            state_in    = S_POP_LAST;
         end

         S_POP_LAST: begin
            cur_in   = rd_data;
            pos_in   = '0;
            state_in = S_DN_CHK;
         end

         S_DN_CHK: begin
            if (!left_ok) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               res_stat_in  = ST_DONE;
               res_count_in = COUNT_W'(count_ff);
               state_in     = S_IDLE;
            end else begin
               rd_addr  = left_idx[IW-1:0];
               state_in = S_DN_RDR;
            end
         end

         S_DN_RDR: begin
            left_in  = rd_data;
            rd_addr  = right_idx[IW-1:0];
            state_in = S_DN_CMP;
         end

         S_DN_CMP: begin
            wr_en = 1'b1;
            if (decision.move) begin
               // move the larger child up, descend one level
               wr_data  = decision.pick_right ? rd_data : left_ff;
               pos_in   = decision.pick_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
               state_in = S_DN_CHK;
            end else begin
               rsp_valid_in = 1'b1;
               res_stat_in  = ST_DONE;
               res_count_in = COUNT_W'(count_ff);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      left_ff      <= left_in;
      res_id_ff    <= res_id_in;
      res_prio_ff  <= res_prio_in;
      res_stat_ff  <= res_stat_in;
      res_count_ff <= res_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_popped_id       = res_id_ff;
   assign rsp_popped_priority = res_prio_ff;
   assign rsp_status          = res_stat_ff;
   assign rsp_entry_count     = res_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while an item is in work");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_opcode == OP_PUSH && count_ff < CW'(CAPACITY))
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted push did not grow the queue");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_stat_ff == ST_EMPTY) |-> (res_count_ff == '0 && res_id_ff == '0))
      else $error("empty pop reports data");

endmodule
